>>> sv/linear_interp_resampler_core_defines.svh
// assertion macros shared by the resampler checker
// no dependencies; the checker that uses them provides clock and reset
`ifndef LINEAR_INTERP_RESAMPLER_CORE_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define LIR_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("resampler check failed");

// next-cycle implication, off during reset
`define LIR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("resampler check failed");

// next-cycle implication that also holds across reset
`define LIR_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("resampler check failed");

`endif

>>> sv/lir_pkg.sv
// shared constants, types and register codes of the linear resampler
// no dependencies
package lir_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int CHANNELS    = 2;
   localparam int MAX_OUTPUTS = 64;
   localparam int STEP_BITS   = 24;
   localparam int CHAN_BITS   = 2;
   localparam int PHASE_BITS  = 25;
   localparam int FRAC_SHIFT  = 16;
   localparam int FRAC_BITS   = FRAC_SHIFT + 1;
   localparam int DIFF_BITS   = SAMPLE_BITS + 1;
   localparam int PROD_BITS   = DIFF_BITS + FRAC_BITS + 1;
   localparam int CNT_BITS    = $clog2(MAX_OUTPUTS + 1);

   localparam logic [PHASE_BITS-1:0] PH_ONE     = PHASE_BITS'(1 << FRAC_SHIFT);
   localparam logic [STEP_BITS-1:0]  STEP_MIN   = STEP_BITS'(1024);
   localparam logic [STEP_BITS-1:0]  STEP_RESET = STEP_BITS'(1 << FRAC_SHIFT);
   localparam logic [CHAN_BITS-1:0]  CHAN_RESET = CHAN_BITS'(2);
   localparam logic [CHAN_BITS-1:0]  CHAN_MONO  = CHAN_BITS'(1);
   localparam logic [PROD_BITS-1:0]  ROUND_BIAS = PROD_BITS'((64'd1 << FRAC_SHIFT) - 64'd1);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef enum logic [0:0] {
      CSR_STEP     = 1'b0,
      CSR_CHANNELS = 1'b1
   } csr_index_type;

   // control that travels with a product from the sequencer to the merge stage
   typedef struct packed {
      logic vld;
      logic last;
      logic mono;
   } stage_type;

endpackage

>>> sv/lir_lane.sv
// one channel lane: difference, registered product, truncating scale and add
// depends on lir_pkg
module lir_lane (
   input  logic                             clock,
   input  logic                             load,
   input  lir_pkg::sample_type              prev_sample,
   input  lir_pkg::sample_type              cur_sample,
   input  logic [lir_pkg::FRAC_BITS-1:0]    frac,
   output lir_pkg::sample_type              result
);

   logic signed [lir_pkg::DIFF_BITS-1:0] diff;
   logic signed [lir_pkg::PROD_BITS-1:0] prod_in;
   logic signed [lir_pkg::PROD_BITS-1:0] prod_ff;
   lir_pkg::sample_type                  base_in;
   lir_pkg::sample_type                  base_ff;
   logic signed [lir_pkg::PROD_BITS-1:0] adj;
   logic signed [lir_pkg::PROD_BITS-1:0] quot;

   assign diff    = {cur_sample[lir_pkg::SAMPLE_BITS-1], cur_sample}
                  - {prev_sample[lir_pkg::SAMPLE_BITS-1], prev_sample};
   assign prod_in = $signed({1'b0, frac}) * diff;
   assign base_in = prev_sample;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
         base_ff <= base_in;
      end
   end

   // bias negative products so the arithmetic shift truncates toward zero
   assign adj    = prod_ff + (prod_ff[lir_pkg::PROD_BITS-1] ? lir_pkg::ROUND_BIAS : '0);
   assign quot   = adj >>> lir_pkg::FRAC_SHIFT;
   // result lies between prev and cur, so wrap-around add is exact
   assign result = base_ff + lir_pkg::sample_type'(quot[lir_pkg::SAMPLE_BITS-1:0]);

endmodule

>>> sv/lir_merge.sv
// merge stage: combines lane results into the output register and handshake
// depends on lir_pkg
module lir_merge (
   input  logic                 clock,
   input  logic                 reset,
   input  lir_pkg::stage_type   stage,
   input  lir_pkg::sample_type  lane0_result,
   input  lir_pkg::sample_type  lane1_result,
   output logic                 take,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lir_pkg::sample_type  rsp_out_ch0,
   output lir_pkg::sample_type  rsp_out_ch1,
   output logic                 rsp_last
);

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   lir_pkg::sample_type ch0_ff;
   lir_pkg::sample_type ch1_ff;
   logic                last_ff;

   assign take = stage.vld && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         ch0_ff  <= lane0_result;
         ch1_ff  <= stage.mono ? '0 : lane1_result;
         last_ff <= stage.last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_ch0 = ch0_ff;
   assign rsp_out_ch1 = ch1_ff;
   assign rsp_last    = last_ff;

endmodule

>>> sv/linear_interp_resampler_core.sv
// top level of the linear-interpolation resampler: sequencer, two lanes, merge
// depends on lir_pkg, lir_lane, lir_merge
//
// usage
//   req_* carries one input frame per beat (two signed 24-bit samples);
//   rsp_* returns zero to 64 interpolated frames per input beat, rsp_last
//   marks the final frame caused by that input
//   csr_* writes step (index 0, unsigned q8.16) and channels_in_use
//   (index 1); write only while the block is idle
// timing
//   one input at a time: req_ready is high only while the sequencer idles
//   an input with n results occupies the sequencer 2 + n cycles: the accept
//   cycle, one issue cycle per result and one cycle to retire the frame
//   the lane multiply is registered, so the first result shows on rsp_valid
//   two cycles after the accepting edge; later results follow one a cycle
// reset
//   step = 1.0, two channels, previous frame zero, phase one, so the first
//   result equals the first input; no clearing pass, ready right after reset
// stall
//   a low rsp_ready holds the output register, then the product stage, then
//   the sequencer; nothing is lost and the input side stays blocked meanwhile
module linear_interp_resampler_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  lir_pkg::sample_type                req_ch0_sample,
   input  lir_pkg::sample_type                req_ch1_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output lir_pkg::sample_type                rsp_out_ch0,
   output lir_pkg::sample_type                rsp_out_ch1,
   output logic                               rsp_last,
   input  logic                               csr_we,
   input  logic [0:0]                         csr_index,
   input  logic [lir_pkg::STEP_BITS-1:0]      csr_wdata
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type                        state_ff, state_in;
   logic [lir_pkg::STEP_BITS-1:0]    step_ff, step_in;
   logic [lir_pkg::CHAN_BITS-1:0]    chan_ff, chan_in;
   logic [lir_pkg::PHASE_BITS-1:0]   phase_ff, phase_in;
   logic [lir_pkg::CNT_BITS-1:0]     cnt_ff, cnt_in;
   lir_pkg::sample_type              prev0_ff, prev0_in;
   lir_pkg::sample_type              prev1_ff, prev1_in;
   lir_pkg::sample_type              cur0_ff, cur0_in;
   lir_pkg::sample_type              cur1_ff, cur1_in;
   lir_pkg::stage_type               stage_ff, stage_in;

   logic [lir_pkg::STEP_BITS-1:0]    step_eff;
   logic [lir_pkg::PHASE_BITS-1:0]   phase_sum;
   logic                             mono;
   logic                             more;
   logic                             stage_free;
   logic                             issue;
   logic                             take;
   lir_pkg::sample_type              lane0_result;
   lir_pkg::sample_type              lane1_result;

   // steps below 1/64 are raised to 1/64
   assign step_eff  = (step_ff < lir_pkg::STEP_MIN) ? lir_pkg::STEP_MIN : step_ff;
   // channel codes 0 and 3 behave as stereo
   assign mono      = (lir_pkg::CHANNELS == 1) || (chan_ff == lir_pkg::CHAN_MONO);
   // phase is at most one whenever we issue, so the sum stays inside 25 bits
   assign phase_sum = phase_ff + lir_pkg::PHASE_BITS'(step_eff);
   // another output is due while phase <= 1 and the per-input cap is not hit
   assign more      = (phase_ff <= lir_pkg::PH_ONE)
                   && (cnt_ff < lir_pkg::CNT_BITS'(lir_pkg::MAX_OUTPUTS));
   assign stage_free = !stage_ff.vld || take;
   assign issue      = (state_ff == ST_RUN) && more && stage_free;
   assign req_ready  = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      chan_in  = chan_ff;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      prev0_in = prev0_ff;
      prev1_in = prev1_ff;
      cur0_in  = cur0_ff;
      cur1_in  = cur1_ff;
      stage_in = stage_ff;

      // register writes
      if (csr_we) begin
         unique case (lir_pkg::csr_index_type'(csr_index))
            lir_pkg::CSR_STEP: begin
               step_in = csr_wdata;
            end
            lir_pkg::CSR_CHANNELS: begin
               chan_in = csr_wdata[lir_pkg::CHAN_BITS-1:0];
            end
            default: begin
               step_in = step_ff;
            end
         endcase
      end

      // product stage drains into the merge register
      if (take) begin
         stage_in.vld = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur0_in  = req_ch0_sample;
               cur1_in  = req_ch1_sample;
               cnt_in   = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!more) begin
               // retire the frame: phase drops by one, saturating at zero
               phase_in = (phase_ff >= lir_pkg::PH_ONE) ? (phase_ff - lir_pkg::PH_ONE) : '0;
               prev0_in = cur0_ff;
               prev1_in = cur1_ff;
               state_in = ST_IDLE;
            end else if (issue) begin
               phase_in      = phase_sum;
               cnt_in        = cnt_ff + lir_pkg::CNT_BITS'(1);
               stage_in.vld  = 1'b1;
               stage_in.mono = mono;
               // last when the next phase passes one or the cap is reached
               stage_in.last = (phase_sum > lir_pkg::PH_ONE)
                            || (cnt_ff == lir_pkg::CNT_BITS'(lir_pkg::MAX_OUTPUTS - 1));
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= lir_pkg::STEP_RESET;
         chan_ff  <= lir_pkg::CHAN_RESET;
         phase_ff <= lir_pkg::PH_ONE;
         cnt_ff   <= '0;
         prev0_ff <= '0;
         prev1_ff <= '0;
         stage_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         chan_ff  <= chan_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         prev0_ff <= prev0_in;
         prev1_ff <= prev1_in;
         stage_ff <= stage_in;
      end
   end

   // current frame is payload only
   always_ff @(posedge clock) begin
      cur0_ff <= cur0_in;
      cur1_ff <= cur1_in;
   end

   // one lane per channel, both fed the same fractional phase
   lir_lane u_lane0 (
      .clock       (clock),
      .load        (issue),
      .prev_sample (prev0_ff),
      .cur_sample  (cur0_ff),
      .frac        (phase_ff[lir_pkg::FRAC_BITS-1:0]),
      .result      (lane0_result)
   );

   lir_lane u_lane1 (
      .clock       (clock),
      .load        (issue),
      .prev_sample (prev1_ff),
      .cur_sample  (cur1_ff),
      .frac        (phase_ff[lir_pkg::FRAC_BITS-1:0]),
      .result      (lane1_result)
   );

   // merge: mono zeroing, last flag and the output register
   lir_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .stage        (stage_ff),
      .lane0_result (lane0_result),
      .lane1_result (lane1_result),
      .take         (take),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_ch0  (rsp_out_ch0),
      .rsp_out_ch1  (rsp_out_ch1),
      .rsp_last     (rsp_last)
   );

endmodule

>>> sv/lir_checker.sv
// port-level checks of the resampler, attached to the top level by bind
// depends on lir_pkg and linear_interp_resampler_core_defines.svh
`include "linear_interp_resampler_core_defines.svh"

module lir_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  lir_pkg::sample_type             rsp_out_ch0,
   input  lir_pkg::sample_type             rsp_out_ch1,
   input  logic                            rsp_last,
   input  logic                            csr_we,
   input  logic [0:0]                      csr_index,
   input  logic [lir_pkg::STEP_BITS-1:0]   csr_wdata
);

   logic mono_ff;
   logic mono_in;

   // shadow of the channel count as written on the port
   always_comb begin
      mono_in = mono_ff;
      if (csr_we && (lir_pkg::csr_index_type'(csr_index) == lir_pkg::CSR_CHANNELS)) begin
         mono_in = (lir_pkg::CHANNELS == 1)
                || (csr_wdata[lir_pkg::CHAN_BITS-1:0] == lir_pkg::CHAN_MONO);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mono_ff <= (lir_pkg::CHANNELS == 1);
      end else begin
         mono_ff <= mono_in;
      end
   end

   `LIR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_out_ch0) && $stable(rsp_out_ch1) && $stable(rsp_last))
   `LIR_ASSERT_NEXT_ALWAYS(a_rsp_reset, reset, !rsp_valid)
   `LIR_ASSERT_IMPL(a_mono_zero, rsp_valid && mono_ff, rsp_out_ch1 == '0)
   `LIR_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

endmodule

bind linear_interp_resampler_core lir_checker u_lir_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_out_ch0 (rsp_out_ch0),
   .rsp_out_ch1 (rsp_out_ch1),
   .rsp_last    (rsp_last),
   .csr_we      (csr_we),
   .csr_index   (csr_index),
   .csr_wdata   (csr_wdata)
);
